>>> src/assert_macros.svh
// assertion macros used by two_queue_interleaver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every edge out of reset
`define TQI_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: lbl");

// consequent holds in the cycle after the antecedent
`define TQI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`else

`define TQI_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define TQI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> src/tqi_pkg.sv
// package: sizes, command and status codes of the two queue interleaver
`default_nettype none

package tqi_pkg;

	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PTR_W  = $clog2(DEPTH + 1);
	localparam int VAL_W  = 32;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_A = 2'd0,
		FN_PUSH_B = 2'd1,
		FN_DRAIN  = 2'd2,
		// reserved code, ignored by the block
		FN_UNUSED = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_PUSHED = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_ITEM   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

endpackage

`default_nettype wire

>>> src/tqi_in_if.sv
// command channel: func and item_value with valid/ready
`default_nettype none

interface tqi_in_if import tqi_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [FUNC_W-1:0]       func;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output func, output item_value, input ready);
	modport sink   (input valid, input func, input item_value, output ready);
endinterface

`default_nettype wire

>>> src/tqi_out_if.sv
// result channel: out_value, status and last with valid/ready
`default_nettype none

interface tqi_out_if import tqi_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_value;
	logic [STAT_W-1:0]       status;
	logic                    last;

	modport source (output valid, output out_value, output status, output last, input ready);
	modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

`default_nettype wire

>>> src/two_queue_interleaver.sv
// two queue interleaver: two linear queues drained alternately into the result channel
//
// req carries one command word: push item_value to queue A, push to queue B,
// or interleave. rsp carries result words with status and a last flag.
// A push gives one result word (pushed, or full and dropped) in the cycle after
// it is taken; a queue never rewinds, so once its tail reaches DEPTH it stays full.
// An interleave with both queues empty gives one empty word in the cycle after it.
// Otherwise the drain sequencer reads one entry per cycle from the head of
// A or B while the receiver does not stall, alternating while both hold data,
// and writes it to the output register: the command first sets state_q to
// S_DRAIN, then items follow, at most DEPTH words; the rest are removed and dropped.
// req.ready is low while draining and while a result waits in the full
// output register; a stalled receiver simply holds the sequencer.
// Reset clears the heads, tails and output valid; queue contents are only
// read once written.
`default_nettype none
`include "assert_macros.svh"

module two_queue_interleaver import tqi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tqi_in_if.sink    req,
	tqi_out_if.source rsp
);

	typedef enum logic {S_IDLE, S_DRAIN} state_t;

	state_t                  state_q;
	logic [PTR_W-1:0]        head_a_q, tail_a_q, head_b_q, tail_b_q;
	logic [ADDR_W-1:0]       cnt_q;
	logic                    turn_b_q;
	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [STAT_W-1:0]       status_q;
	logic                    last_q;

	logic signed [VAL_W-1:0] store_a_q [DEPTH];
	logic signed [VAL_W-1:0] store_b_q [DEPTH];

	logic                    out_free, accept;
	logic                    a_has, b_has, pick_a, a_left, b_left, drain_last;
	logic                    full_a, full_b, wr_a, wr_b;
	logic signed [VAL_W-1:0] rd_a, rd_b, pop_value;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	assign full_a = (tail_a_q == PTR_W'(DEPTH));
	assign full_b = (tail_b_q == PTR_W'(DEPTH));
	assign wr_a   = accept && (req.func == FN_PUSH_A) && !full_a;
	assign wr_b   = accept && (req.func == FN_PUSH_B) && !full_b;

	assign a_has = head_a_q < tail_a_q;
	assign b_has = head_b_q < tail_b_q;
	// alternate while both hold data, then whichever is left
	assign pick_a = a_has && (!b_has || !turn_b_q);

	// head is below tail when read, so the low bits address a written entry
	assign rd_a      = store_a_q[head_a_q[ADDR_W-1:0]];
	assign rd_b      = store_b_q[head_b_q[ADDR_W-1:0]];
	assign pop_value = pick_a ? rd_a : rd_b;

	assign a_left     = pick_a ? ((head_a_q + PTR_W'(1)) < tail_a_q) : a_has;
	assign b_left     = pick_a ? b_has : ((head_b_q + PTR_W'(1)) < tail_b_q);
	assign drain_last = (cnt_q == ADDR_W'(DEPTH - 1)) || (!a_left && !b_left);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			store_a_q[tail_a_q[ADDR_W-1:0]] <= req.item_value;
		end
		if (wr_b) begin
			store_b_q[tail_b_q[ADDR_W-1:0]] <= req.item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_a_q    <= '0;
			tail_a_q    <= '0;
			head_b_q    <= '0;
			tail_b_q    <= '0;
			cnt_q       <= '0;
			turn_b_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			out_value_q <= '0;
			status_q    <= STAT_PUSHED;
			last_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.func) inside
							FN_PUSH_A, FN_PUSH_B: begin
								rsp_valid_q <= 1'b1;
								out_value_q <= '0;
								last_q      <= 1'b1;
								if ((req.func == FN_PUSH_A) ? full_a : full_b) begin
									status_q <= STAT_FULL;
								end else begin
									status_q <= STAT_PUSHED;
									if (req.func == FN_PUSH_A) begin
										tail_a_q <= tail_a_q + PTR_W'(1);
									end else begin
										tail_b_q <= tail_b_q + PTR_W'(1);
									end
								end
							end
							FN_DRAIN: begin
								if (!a_has && !b_has) begin
									rsp_valid_q <= 1'b1;
									out_value_q <= '0;
									status_q    <= STAT_EMPTY;
									last_q      <= 1'b1;
								end else begin
									state_q  <= S_DRAIN;
									cnt_q    <= '0;
									turn_b_q <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						out_value_q <= pop_value;
						status_q    <= STAT_ITEM;
						last_q      <= drain_last;
						turn_b_q    <= pick_a;
						cnt_q       <= cnt_q + ADDR_W'(1);
						if (drain_last) begin
							// words beyond the output limit are removed unseen
							head_a_q <= tail_a_q;
							head_b_q <= tail_b_q;
							state_q  <= S_IDLE;
						end else if (pick_a) begin
							head_a_q <= head_a_q + PTR_W'(1);
						end else begin
							head_b_q <= head_b_q + PTR_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_value = out_value_q;
	assign rsp.status    = status_q;
	assign rsp.last      = last_q;

	`TQI_ASSERT_ALWAYS(a_ptr_a, clk, arst_n, (head_a_q <= tail_a_q) && (tail_a_q <= PTR_W'(DEPTH)))
	`TQI_ASSERT_ALWAYS(a_ptr_b, clk, arst_n, (head_b_q <= tail_b_q) && (tail_b_q <= PTR_W'(DEPTH)))
	`TQI_ASSERT_ALWAYS(a_drain_has_data, clk, arst_n, (state_q != S_DRAIN) || a_has || b_has)
	`TQI_ASSERT_NEXT(a_resp, clk, arst_n, accept && (req.func != FN_UNUSED), rsp_valid_q || state_q != S_IDLE)

endmodule

`default_nettype wire
